[hdl/contiguous_ring_region_manager_defines.svh]
// ----------------------------------------------------------------------------
// contiguous ring region manager assertion macros
// shared property forms for the assertions of the region manager
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_RING_REGION_MANAGER_DEFINES_SVH
`define CONTIGUOUS_RING_REGION_MANAGER_DEFINES_SVH

// same cycle implication
`define CRRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication
`define CRRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/crrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_pkg
// types and constants shared by the ring region manager files
// ----------------------------------------------------------------------------
package crrm_pkg;

    localparam int POS_W = 13;
    localparam int OFF_W = 12;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [POS_W-1:0] BUFFER_SIZE_RST = 13'd4096;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_QUERY   = 2'd1,
        OP_FINISH  = 2'd2,
        OP_RECOVER = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_AFTER   = 2'd0,
        ST_START   = 2'd1,
        ST_BEFORE  = 2'd2,
        ST_NO_ROOM = 2'd3
    } t_status;

    typedef struct packed {
        t_op              operation;
        logic [POS_W-1:0] length;
        logic [POS_W-1:0] max_need;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] region_offset;
        logic [POS_W-1:0] region_size;
        logic [POS_W-1:0] saved_write;
        logic [POS_W-1:0] saved_read;
        logic [POS_W-1:0] saved_end;
    } t_result;

endpackage

[hdl/crrm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm request and response interfaces
// valid/ready channels carrying one operation word and one result word
// ----------------------------------------------------------------------------
interface crrm_req_if import crrm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [POS_W-1:0] length;
    logic [POS_W-1:0] max_need;

    modport source (output valid, operation, length, max_need, input ready);
    modport sink (input valid, operation, length, max_need, output ready);
endinterface

interface crrm_rsp_if import crrm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [OFF_W-1:0] region_offset;
    logic [POS_W-1:0] region_size;
    logic [POS_W-1:0] saved_write;
    logic [POS_W-1:0] saved_read;
    logic [POS_W-1:0] saved_end;

    modport source (output valid, status, region_offset, region_size,
                    saved_write, saved_read, saved_end, input ready);
    modport sink (input valid, status, region_offset, region_size,
                  saved_write, saved_read, saved_end, output ready);
endinterface

[hdl/crrm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_core
// index state of the ring and the single pass decision for one word
// ----------------------------------------------------------------------------
`include "contiguous_ring_region_manager_defines.svh"

module crrm_core import crrm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_commit,
    input  t_item            i_item,
    input  logic [POS_W-1:0] i_size,
    output t_result          o_result
);

    logic [POS_W-1:0] r_write_pos, n_write_pos;
    logic [POS_W-1:0] r_read_pos,  n_read_pos;
    logic [POS_W-1:0] r_end_mark,  n_end_mark;

    logic [POS_W:0] w_plus_len;
    logic [POS_W:0] w_plus_need;
    logic [POS_W:0] r_plus_len;
    logic [POS_W:0] size_ext;
    logic [POS_W:0] r_ext;
    logic [POS_W:0] e_ext;
    logic [POS_W:0] w_ext;
    t_result        res;

    assign w_plus_len  = {1'b0, r_write_pos} + {1'b0, i_item.length};
    assign w_plus_need = {1'b0, r_write_pos} + {1'b0, i_item.max_need};
    assign r_plus_len  = {1'b0, r_read_pos} + {1'b0, i_item.length};
    assign size_ext    = {1'b0, i_size};
    assign r_ext       = {1'b0, r_read_pos};
    assign e_ext       = {1'b0, r_end_mark};
    assign w_ext       = {1'b0, r_write_pos};

    always_comb begin
        res          = '0;
        res.status   = ST_AFTER;
        n_write_pos  = r_write_pos;
        n_read_pos   = r_read_pos;
        n_end_mark   = r_end_mark;
        unique case (i_item.operation)
            OP_WRITE: begin
                res.status = ST_NO_ROOM;
                if (r_write_pos >= r_read_pos) begin
                    if (size_ext > w_plus_len && size_ext > w_plus_need) begin
                        res.status        = ST_AFTER;
                        res.region_offset = r_write_pos[OFF_W-1:0];
                        n_write_pos       = w_plus_len[POS_W-1:0];
                    end else if (r_read_pos > i_item.max_need && r_read_pos > i_item.length) begin
                        res.status  = ST_START;
                        n_end_mark  = r_write_pos;
                        n_write_pos = i_item.length;
                    end
                end else if (r_ext > w_plus_len && r_ext > w_plus_need) begin
                    res.status        = ST_BEFORE;
                    res.region_offset = r_write_pos[OFF_W-1:0];
                    n_write_pos       = w_plus_len[POS_W-1:0];
                end
            end
            OP_QUERY: begin
                if (r_write_pos != r_read_pos) begin
                    if (r_read_pos < r_write_pos) begin
                        res.region_offset = r_read_pos[OFF_W-1:0];
                        res.region_size   = r_write_pos - r_read_pos;
                    end else if (r_end_mark != '0 && r_read_pos < r_end_mark) begin
                        res.region_offset = r_read_pos[OFF_W-1:0];
                        res.region_size   = r_end_mark - r_read_pos;
                    end else if (r_end_mark == '0 && r_read_pos < i_size) begin
                        res.region_offset = r_read_pos[OFF_W-1:0];
                        res.region_size   = i_size - r_read_pos;
                    end else begin
                        res.region_size = r_write_pos;
                    end
                end
            end
            OP_FINISH: begin
                if (r_write_pos > r_read_pos) begin
                    n_read_pos = (r_plus_len > w_ext) ? r_write_pos : r_plus_len[POS_W-1:0];
                end else if (r_end_mark != '0 && r_plus_len < e_ext) begin
                    n_read_pos = r_plus_len[POS_W-1:0];
                end else if (r_end_mark == '0 && r_plus_len < size_ext) begin
                    n_read_pos = r_plus_len[POS_W-1:0];
                end else begin
                    n_read_pos = '0;
                    n_end_mark = '0;
                end
            end
            OP_RECOVER: begin
                res.saved_write = r_write_pos;
                res.saved_read  = r_read_pos;
                res.saved_end   = r_end_mark;
                if (r_read_pos < r_write_pos) begin
                    n_read_pos = r_write_pos;
                end else if (r_read_pos > r_write_pos) begin
                    n_read_pos = r_end_mark;
                end
            end
            default: begin
                res.status = ST_NO_ROOM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos <= '0;
            r_read_pos  <= '0;
            r_end_mark  <= '0;
        end else if (i_commit) begin
            r_write_pos <= n_write_pos;
            r_read_pos  <= n_read_pos;
            r_end_mark  <= n_end_mark;
        end
    end

    assign o_result = res;

    `CRRM_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_commit, $stable(r_write_pos) && $stable(r_read_pos) && $stable(r_end_mark), "indices moved without a word")
    `CRRM_ASSERT_NEXT(a_no_room_holds, i_clk, i_rst_n, i_commit && i_item.operation == OP_WRITE && res.status == ST_NO_ROOM, $stable(r_write_pos) && $stable(r_read_pos) && $stable(r_end_mark), "failed reserve changed indices")
    `CRRM_ASSERT_NOW(a_empty_query, i_clk, i_rst_n, i_item.operation == OP_QUERY && r_write_pos == r_read_pos, res.region_size == '0 && res.region_offset == '0, "empty ring reported data")

endmodule

[hdl/contiguous_ring_region_manager.sv]
`timescale 1ns / 1ps
// order: a word waits in the request stage until the result stage is free
// throughput: one request word per cycle unless o_rsp stalls; a word's index
//   update is a single compare/add pass between request and result registers
// reset: synchronous active low; indices clear to zero, buffer_size to 4096,
//   no word is held in either stage
// ----------------------------------------------------------------------------
// contiguous_ring_region_manager
// top level: apb register, request stage and result stage around the core
// ----------------------------------------------------------------------------
module contiguous_ring_region_manager import crrm_pkg::*; #(
    parameter int MAX_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    crrm_req_if.sink          i_req,
    crrm_rsp_if.source        o_rsp
);

    localparam logic [POS_W-1:0] SIZE_CLAMP =
        (MAX_BYTES > int'(POS_MAX)) ? POS_MAX : POS_W'(MAX_BYTES);

    logic [POS_W-1:0] r_buffer_size;
    logic [POS_W-1:0] eff_size;
    logic             reg_sel;

    logic    r_s1_vld;
    t_item   r_s1_item;
    logic    r_out_vld;
    t_result r_out;
    t_result core_res;
    logic    out_free;
    logic    s1_adv;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == REG_BUFFER_SIZE);
    assign prdata  = reg_sel ? {{(APB_DW-POS_W){1'b0}}, r_buffer_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_buffer_size <= pwdata[POS_W-1:0];
        end
    end

    always_comb begin
        if (r_buffer_size == '0) begin
            eff_size = POS_W'(1);
        end else if (r_buffer_size > SIZE_CLAMP) begin
            eff_size = SIZE_CLAMP;
        end else begin
            eff_size = r_buffer_size;
        end
    end

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign s1_adv      = r_s1_vld && out_free;
    assign i_req.ready = !r_s1_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_item.operation <= t_op'(i_req.operation);
            r_s1_item.length    <= i_req.length;
            r_s1_item.max_need  <= i_req.max_need;
        end
    end

    crrm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (s1_adv),
        .i_item   (r_s1_item),
        .i_size   (eff_size),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= core_res;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.region_offset = r_out.region_offset;
    assign o_rsp.region_size   = r_out.region_size;
    assign o_rsp.saved_write   = r_out.saved_write;
    assign o_rsp.saved_read    = r_out.saved_read;
    assign o_rsp.saved_end     = r_out.saved_end;

endmodule
